// ===== hdl/fbf_pkg.sv =====
// ----------------------------------------------------------------------------
// fbf_pkg: shared types and constants of the fire blur and fade filter
// Pixel and window types, kernel kinds, register indexes, queue entry.
// ----------------------------------------------------------------------------
package fbf_pkg;

	localparam int PIX_W         = 24;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int HEIGHT_MAX    = 1024;
	localparam int ROW_W         = 10;
	localparam int OCOL_W        = 10;
	localparam int Q_DEPTH       = 4;

	// configuration register indexes
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_FADE   = 2'd2;
	localparam logic [1:0] CFG_ORDER  = 2'd3;

	// kernels: full 3x3; edge, cols 1-2, [1][1] doubled; edge, cols 0-1, [1][0] doubled
	localparam logic [1:0] KIND_FULL   = 2'd0;
	localparam logic [1:0] KIND_EDGE_L = 2'd1;
	localparam logic [1:0] KIND_EDGE_R = 2'd2;

	typedef logic [PIX_W-1:0] pix_t;
	// [row][col], row 0 above, 1 centre, 2 newest; col 2 newest
	typedef pix_t [2:0][2:0] win_t;

	typedef struct packed {
		logic [10:0] width;
		logic [10:0] height;
		logic [7:0]  fade_step;
		logic        channel_order;
	} cfg_t;

	typedef struct packed {
		win_t              win;
		logic              a_vld;
		logic [1:0]        a_kind;
		logic [OCOL_W-1:0] a_col;
		logic              b_vld;
		logic [OCOL_W-1:0] b_col;
		logic [ROW_W-1:0]  row;
	} entry_t;

endpackage

// ===== hdl/fbf_front.sv =====
// ----------------------------------------------------------------------------
// fbf_front: pixel intake, line stores, window and result classification
// Reads the line stores at accept, updates window and stores at commit.
// ----------------------------------------------------------------------------
module fbf_front import fbf_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  pix_t             src_pixel,
	input  logic [1:0]       ripple,
	output logic             push,
	output entry_t           push_entry,
	input  logic             q_full
);
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;
	localparam int XW = (CW + 1 > OCOL_W) ? CW + 1 : OCOL_W;

	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_s1;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [1:0]       shift_q;
	win_t             win_q;

	logic             v_s1;
	pix_t             pix_s1;
	logic [1:0]       rip_s1;
	logic [CW-1:0]    c_s1;
	logic [ROW_W-1:0] r_s1;

	logic [WW-1:0]    w_ext;
	logic [CW:0]      w;
	logic [10:0]      h;
	logic [CW-1:0]    c0;
	logic [ROW_W-1:0] r0;
	logic             accept, commit, has_res;
	logic [1:0]       shift_n;
	win_t             win_n;
	logic [CW:0]      lo, hi, s_a;
	logic             a_in;
	logic [XW-1:0]    sh_ext;

	// saturate the sizes
	always_comb begin
		w_ext = WW'(cfg.width);
		if (w_ext < WW'(3))
			w = (CW+1)'(3);
		else if (w_ext > WW'(MAX_WIDTH))
			w = (CW+1)'(MAX_WIDTH);
		else
			w = w_ext[CW:0];
		if (cfg.height < 11'd3)
			h = 11'd3;
		else if (cfg.height > 11'(HEIGHT_MAX))
			h = 11'(HEIGHT_MAX);
		else
			h = cfg.height;
		c0 = ({1'b0, col_q} >= w) ? CW'(w - 1'b1) : col_q;
		r0 = ({1'b0, row_q} >= h) ? ROW_W'(h - 1'b1) : row_q;
	end

	assign accept   = in_valid && !in_stall;
	assign in_stall = v_s1 && !commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if ({1'b0, c0} + 1'b1 >= w) begin
				col_q <= '0;
				row_q <= ({1'b0, r0} + 1'b1 >= h) ? '0 : r0 + 1'b1;
			end else begin
				col_q <= c0 + 1'b1;
				row_q <= r0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (accept)
			v_s1 <= 1'b1;
		else if (commit)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= src_pixel;
			rip_s1 <= ripple;
			c_s1   <= c0;
			r_s1   <= r0;
			rd_s1  <= line_mem[c0];
		end
		if (commit) begin
			line_mem[c_s1] <= {rd_s1[PIX_W-1:0], pix_s1};
		end
	end

	// shift the window and classify the results of this pixel
	always_comb begin
		if (c_s1 == '0)
			shift_n = (rip_s1 == 2'd0) ? 2'd0 : ((rip_s1 == 2'd1) ? 2'd1 : 2'b11);
		else
			shift_n = shift_q;
		for (int i = 0; i < 3; i++) begin
			win_n[i][0] = win_q[i][1];
			win_n[i][1] = win_q[i][2];
		end
		win_n[0][2] = rd_s1[2*PIX_W-1:PIX_W];
		win_n[1][2] = rd_s1[PIX_W-1:0];
		win_n[2][2] = pix_s1;

		lo     = (shift_n == 2'd1) ? (CW+1)'(1) : '0;
		hi     = shift_n[1] ? w - (CW+1)'(2) : w - (CW+1)'(1);
		s_a    = {1'b0, c_s1} - 1'b1;
		sh_ext = {{(XW-1){shift_n[1]}}, shift_n[0]};
		a_in   = (c_s1 != '0) && (s_a >= lo) && (s_a <= hi);

		push_entry.win    = win_n;
		push_entry.row    = r_s1 - ROW_W'(2);
		push_entry.a_vld  = (r_s1 >= ROW_W'(2)) && a_in;
		push_entry.a_kind = (s_a == lo) ? KIND_EDGE_L :
			((s_a == hi) ? KIND_EDGE_R : KIND_FULL);
		push_entry.a_col  = OCOL_W'(XW'(s_a) - sh_ext);
		push_entry.b_vld  = (r_s1 >= ROW_W'(2)) && ({1'b0, c_s1} == w - 1'b1) && !shift_n[1];
		push_entry.b_col  = OCOL_W'(XW'(w - 1'b1) - sh_ext);
		has_res = push_entry.a_vld || push_entry.b_vld;
	end

	assign commit = v_s1 && (!has_res || !q_full);
	assign push   = commit && has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			shift_q <= 2'd0;
		else if (commit)
			shift_q <= shift_n;
	end

	always_ff @(posedge clk) begin
		if (commit)
			win_q <= win_n;
	end

endmodule

// ===== hdl/fbf_queue.sv =====
// ----------------------------------------------------------------------------
// fbf_queue: short queue between classification and kernel evaluation
// Register-based FIFO, head read combinationally.
// ----------------------------------------------------------------------------
module fbf_queue import fbf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   nempty,
	output entry_t head
);
	localparam int PW = $clog2(Q_DEPTH);

	entry_t           mem_q [Q_DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;

	assign full   = (cnt_q == (PW+1)'(Q_DEPTH));
	assign nempty = (cnt_q != '0);
	assign head   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && !nempty))
		else $error("queue pop while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(Q_DEPTH))
		else $error("queue count out of range");

endmodule

// ===== hdl/fbf_back.sv =====
// ----------------------------------------------------------------------------
// fbf_back: kernel evaluation and fade
// Issues one or two results per queue entry through a two-stage pipeline.
// ----------------------------------------------------------------------------
module fbf_back import fbf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              nempty,
	input  entry_t            head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output pix_t              out_pixel,
	output logic [OCOL_W-1:0] out_column,
	output logic [ROW_W-1:0]  out_row,
	output logic              run_last
);
	function automatic logic [7:0] chv(input pix_t p, input int j);
		return p[PIX_W-1-8*j -: 8];
	endfunction

	function automatic logic [7:0] blur(input win_t wn, input logic [1:0] kind, input int j);
		logic [11:0] s;
		s = '0;
		case (kind)
			KIND_EDGE_L: begin
				for (int i = 0; i < 3; i++)
					s = s + 12'(chv(wn[i][1], j)) + 12'(chv(wn[i][2], j));
				s = s + 12'(chv(wn[1][1], j));
				blur = s[10:3];
			end
			KIND_EDGE_R: begin
				for (int i = 0; i < 3; i++)
					s = s + 12'(chv(wn[i][0], j)) + 12'(chv(wn[i][1], j));
				s = s + 12'(chv(wn[1][0], j));
				blur = s[10:3];
			end
			default: begin
				for (int i = 0; i < 3; i++) begin
					s = s + ((12'(chv(wn[i][0], j)) + 12'(chv(wn[i][2], j))
						+ {3'd0, chv(wn[i][1], j), 1'b0}) << ((i == 1) ? 1 : 0));
				end
				blur = s[11:4];
			end
		endcase
	endfunction

	function automatic logic [7:0] fade(input logic [7:0] v, input logic [7:0] st);
		return (v > st) ? v - st : 8'd0;
	endfunction

	logic        phase_q;
	logic        en1, en2, issue, sel_b;
	logic [1:0]  kind;

	logic              v_s1, last_s1;
	logic [7:0]        ch_s1 [3];
	logic [OCOL_W-1:0] col_s1;
	logic [ROW_W-1:0]  row_s1;

	logic        v_s2;
	logic [7:0]  f [3];
	logic [1:0]  first, other;

	assign en2   = !v_s2 || !out_stall;
	assign en1   = !v_s1 || en2;
	assign issue = nempty && en1;
	assign sel_b = phase_q || !head.a_vld;
	assign kind  = sel_b ? KIND_EDGE_L : head.a_kind;
	assign pop   = issue && (sel_b || !head.b_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= 1'b0;
		else if (issue)
			phase_q <= !sel_b && head.b_vld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= issue;
			if (en2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			for (int j = 0; j < 3; j++)
				ch_s1[j] <= blur(head.win, kind, j);
			col_s1  <= sel_b ? head.b_col : head.a_col;
			row_s1  <= head.row;
			last_s1 <= sel_b || !head.b_vld;
		end
	end

	// fade the first non-zero channel in priority order
	always_comb begin
		first = cfg.channel_order ? 2'd0 : 2'd2;
		other = cfg.channel_order ? 2'd2 : 2'd0;
		for (int j = 0; j < 3; j++)
			f[j] = ch_s1[j];
		if (ch_s1[first] != 8'd0)
			f[first] = fade(ch_s1[first], cfg.fade_step);
		else if (ch_s1[1] != 8'd0)
			f[1] = fade(ch_s1[1], cfg.fade_step);
		else if (ch_s1[other] != 8'd0)
			f[other] = fade(ch_s1[other], cfg.fade_step);
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			out_pixel  <= {f[0], f[1], f[2]};
			out_column <= col_s1;
			out_row    <= row_s1;
			run_last   <= last_s1;
		end
	end

	assign out_valid = v_s2;

endmodule

// ===== hdl/fire_blur_fade_filter_top.sv =====
// ----------------------------------------------------------------------------
// fire_blur_fade_filter_top: 3x3 fire blur with single-channel fade
// Streams raster pixels in, emits blurred and faded pixels of the row above.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | beat carries
//  --------+-----------+---------------------+-------------------------------
//  in      | sink      | in_valid / in_stall | src_pixel, ripple
//  out     | source    | out_valid/out_stall | out_pixel, out_column, out_row,
//          |           |                     | run_last
//  cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One input beat per clock when the output side keeps up. A pixel passes the
// line-store read stage, then the queue and two kernel/fade stages. The last
// pixel of a row can yield two results, and the back end issues one result
// per clock while out_stall is low, so the four-entry queue absorbs the extra
// beat. Reset clears counters, row shift, queue and pipeline valids; line
// stores are not cleared. The config port is always ready.
//
module fire_blur_fade_filter_top import fbf_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [10:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  pix_t              src_pixel,
	input  logic [1:0]        ripple,
	output logic              out_valid,
	input  logic              out_stall,
	output pix_t              out_pixel,
	output logic [OCOL_W-1:0] out_column,
	output logic [ROW_W-1:0]  out_row,
	output logic              run_last
);
	cfg_t   cfg_q;
	logic   push, q_full, pop, nempty;
	entry_t push_entry, head;

	assign cfg_ready = 1'b1;

	// register writes; reset loads the default frame setup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width         <= 11'd640;
			cfg_q.height        <= 11'd480;
			cfg_q.fade_step     <= 8'd8;
			cfg_q.channel_order <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIDTH:  cfg_q.width         <= cfg_data;
				CFG_HEIGHT: cfg_q.height        <= cfg_data;
				CFG_FADE:   cfg_q.fade_step     <= cfg_data[7:0];
				CFG_ORDER:  cfg_q.channel_order <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front: accept, read line stores, shift window, classify
	fbf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.src_pixel  (src_pixel),
		.ripple     (ripple),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	// decouple the two halves
	fbf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.nempty     (nempty),
		.head       (head)
	);

	// back: evaluate kernels, fade, hold result for the output beat
	fbf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.nempty     (nempty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_pixel  (out_pixel),
		.out_column (out_column),
		.out_row    (out_row),
		.run_last   (run_last)
	);

endmodule
